// ----- hdl/tflp_pkg.sv -----
// shared types and constants for the two-level first-fit packer
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package tflp_pkg;

	localparam int IDX_W = 3;
	localparam int CAP_W = 32;
	localparam int PWR_W = 16;
	localparam int OBJ_W = 32;
	localparam int CFG_W = 4;
	localparam int FUNC_W = 2;

	// request word: router, link, capacity, power, flow size, zero fill
	localparam int IN_DW = 88;
	// result word: forwarded, lost, router, link, objective
	localparam int OUT_DW = 40;

	localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 4'd8;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_ROUTER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_LINK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PACK = 2'd2;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_step;
		logic eval;
		logic mark_lost;
		logic load;
		logic commit;
		logic add_router;
		logic publish;
	} tflp_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} tflp_status_t;

endpackage

`default_nettype wire

// ----- hdl/two_level_first_fit_packer_core.sv -----
// Two-level first-fit flow packer. A load request writes one router or link entry
// (capacity, power, in-use cleared); a pack request scans routers in order, one router
// per clock, comparing all links of that router in parallel from one row read of the
// per-link tables, and charges the power of newly used devices to a saturating
// objective. A load goes through a write step and then the result, and an unused
// function code goes straight to the result; a pack that places its flow goes through
// the scan, the update of the router and link tables with the link power charge, the
// router power charge and the result, and a lost flow through the scan and the result.
// The scan runs up to the first router that holds the flow and has a fitting link, or
// over all scanned routers for a lost flow. The result cycle stretches while the
// previous result still waits in the output register. A new request is accepted while
// the previous result waits there. Entries must be loaded before a flow's scan reads
// them; no clearing pass.
// depends on tflp_pkg, tflp_ctrl and tflp_datapath
`default_nettype none

module two_level_first_fit_packer_core
	import tflp_pkg::*;
#(
	parameter int MAX_ROUTERS = 8,
	parameter int MAX_LINKS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// router_index, link_index, capacity, power, flow_size, zero fill
	input  wire logic [IN_DW-1:0]     s_tdata,
	// func
	input  wire logic [FUNC_W-1:0]    s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// forwarded, lost, chosen_router, chosen_link, objective_total
	output logic [OUT_DW-1:0]         m_tdata
);

	localparam logic REG_ROUTERS = 1'b0;
	localparam logic REG_LINKS = 1'b1;

	logic [CFG_W-1:0] routers_in_use_q;
	logic [CFG_W-1:0] links_in_use_q;
	tflp_cmd_t        cmd;
	tflp_status_t     status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routers_in_use_q <= CFG_COUNT_RESET;
			links_in_use_q <= CFG_COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_ROUTERS: routers_in_use_q <= pwdata[CFG_W-1:0];
				REG_LINKS: links_in_use_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROUTERS: prdata = {28'd0, routers_in_use_q};
			REG_LINKS: prdata = {28'd0, links_in_use_q};
			default: prdata = '0;
		endcase
	end

	tflp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tflp_datapath #(
		.MAX_ROUTERS (MAX_ROUTERS),
		.MAX_LINKS   (MAX_LINKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.s_tuser        (s_tuser),
		.s_tdata        (s_tdata),
		.routers_in_use (routers_in_use_q),
		.links_in_use   (links_in_use_q),
		.m_tdata        (m_tdata)
	);

endmodule

`default_nettype wire

// ----- hdl/tflp_ctrl.sv -----
// sequencing state machine of the packer: request intake, scan, update, result hand-off
// depends on tflp_pkg; drives the datapath through tflp_cmd_t, watches tflp_status_t
`default_nettype none

module tflp_ctrl
	import tflp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [FUNC_W-1:0]    s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire tflp_status_t         status,
	output tflp_cmd_t                 cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EVAL,
		ST_ADD_LINK,
		ST_ADD_ROUTER,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   slot_free;

	assign s_tready = (state_q == ST_IDLE);
	assign slot_free = !m_tvalid || m_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
				cmd.scan_start = s_tvalid && (s_tuser == FUNC_PACK);
			end
			ST_LOAD: cmd.load = 1'b1;
			ST_EVAL: begin
				cmd.eval = 1'b1;
				cmd.mark_lost = !status.hit && status.last;
				cmd.scan_step = !status.hit && !status.last;
			end
			ST_ADD_LINK: cmd.commit = 1'b1;
			ST_ADD_ROUTER: cmd.add_router = 1'b1;
			ST_FINISH: cmd.publish = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tready && !cmd.publish)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							FUNC_PACK: state_q <= ST_EVAL;
							FUNC_LOAD_ROUTER: state_q <= ST_LOAD;
							FUNC_LOAD_LINK: state_q <= ST_LOAD;
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_LOAD: state_q <= ST_FINISH;
				ST_EVAL: begin
					if (status.hit)
						state_q <= ST_ADD_LINK;
					else if (status.last)
						state_q <= ST_FINISH;
				end
				ST_ADD_LINK: state_q <= ST_ADD_ROUTER;
				ST_ADD_ROUTER: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (slot_free) begin
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tflp_datapath.sv -----
// datapath of the packer: router and link tables, parallel link compare, objective
// depends on tflp_pkg; controlled by tflp_ctrl through tflp_cmd_t
`default_nettype none

module tflp_datapath
	import tflp_pkg::*;
#(
	parameter int MAX_ROUTERS = 8,
	parameter int MAX_LINKS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tflp_cmd_t            cmd,
	output tflp_status_t              status,
	input  wire logic [FUNC_W-1:0]    s_tuser,
	input  wire logic [IN_DW-1:0]     s_tdata,
	input  wire logic [CFG_W-1:0]     routers_in_use,
	input  wire logic [CFG_W-1:0]     links_in_use,
	output logic [OUT_DW-1:0]         m_tdata
);

	localparam int RAW = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
	localparam int LAW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int RCW = $clog2(MAX_ROUTERS + 1);
	localparam int LCW = $clog2(MAX_LINKS + 1);

	function automatic logic [OBJ_W-1:0] sat_add(input logic [OBJ_W-1:0] a,
			input logic [PWR_W-1:0] b);
		logic [OBJ_W:0] s;
		s = {1'b0, a} + {{(OBJ_W + 1 - PWR_W){1'b0}}, b};
		return s[OBJ_W] ? '1 : s[OBJ_W-1:0];
	endfunction

	// captured request
	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  ri_q;
	logic [IDX_W-1:0]  li_q;
	logic [CAP_W-1:0]  cap_q;
	logic [PWR_W-1:0]  pwr_q;
	logic [CAP_W-1:0]  flow_q;

	logic [RCW-1:0] nr_c;
	logic [LCW-1:0] nl_c;
	logic           scan_empty;
	logic           ri_ok;

	logic [RAW-1:0] ev_idx_q;
	logic [RAW-1:0] rd_addr;
	logic           rd_en;
	logic [RAW-1:0] load_addr;

	// per-lane read data of the current router row
	logic [CAP_W-1:0] lres_rd [MAX_LINKS];
	logic [PWR_W-1:0] lpwr_rd [MAX_LINKS];
	logic             lon_rd [MAX_LINKS];
	logic [MAX_LINKS-1:0] lfit;
	logic [LAW-1:0]   first_l;
	logic             any_l;

	logic [CAP_W-1:0] rres_mem [MAX_ROUTERS];
	logic [PWR_W-1:0] rpwr_mem [MAX_ROUTERS];
	logic             ron_mem [MAX_ROUTERS];
	logic [CAP_W-1:0] rres_rd_q;
	logic [PWR_W-1:0] rpwr_rd_q;
	logic             ron_rd_q;

	// winner of the scan
	logic [RAW-1:0]   hit_r_q;
	logic [LAW-1:0]   hit_l_q;
	logic [CAP_W-1:0] rres_new_q;
	logic [CAP_W-1:0] lres_new_q;
	logic [PWR_W-1:0] hit_rpwr_q;
	logic [PWR_W-1:0] hit_lpwr_q;
	logic             hit_ron_q;
	logic             hit_lon_q;
	logic             fwd_q;
	logic             lost_q;
	logic [OBJ_W-1:0] obj_q;
	logic [OUT_DW-1:0] out_q;

	assign nr_c = ({28'd0, routers_in_use} > 32'(MAX_ROUTERS)) ?
		RCW'(MAX_ROUTERS) : RCW'(routers_in_use);
	assign nl_c = ({28'd0, links_in_use} > 32'(MAX_LINKS)) ?
		LCW'(MAX_LINKS) : LCW'(links_in_use);
	assign scan_empty = (nr_c == '0);
	assign ri_ok = ({29'd0, ri_q} < 32'(MAX_ROUTERS));
	assign load_addr = RAW'(ri_q);

	assign rd_en = cmd.scan_start || cmd.scan_step;
	assign rd_addr = cmd.scan_start ? '0 : RAW'(ev_idx_q + 1'b1);

	always_comb begin
		first_l = '0;
		any_l = 1'b0;
		for (int l = MAX_LINKS - 1; l >= 0; l--) begin
			if (lfit[l]) begin
				first_l = LAW'(l);
				any_l = 1'b1;
			end
		end
	end

	assign status.hit = !scan_empty && (flow_q <= rres_rd_q) && any_l;
	assign status.last = scan_empty || (RCW'(ev_idx_q) == nr_c - RCW'(1));

	for (genvar l = 0; l < MAX_LINKS; l++) begin : g_lane
		logic [CAP_W-1:0] res_mem [MAX_ROUTERS];
		logic [PWR_W-1:0] pwr_mem [MAX_ROUTERS];
		logic             on_mem [MAX_ROUTERS];
		logic [CAP_W-1:0] res_rd_q;
		logic [PWR_W-1:0] pwr_rd_q;
		logic             on_rd_q;
		logic             load_we;
		logic             commit_we;

		assign load_we = cmd.load && (func_q == FUNC_LOAD_LINK) && ri_ok &&
			({29'd0, li_q} == 32'(l));
		assign commit_we = cmd.commit && (hit_l_q == LAW'(l));

		always_ff @(posedge clk) begin
			if (load_we) begin
				res_mem[load_addr] <= cap_q;
				pwr_mem[load_addr] <= pwr_q;
				on_mem[load_addr] <= 1'b0;
			end else if (commit_we) begin
				res_mem[hit_r_q] <= lres_new_q;
				on_mem[hit_r_q] <= 1'b1;
			end
			if (rd_en) begin
				res_rd_q <= res_mem[rd_addr];
				pwr_rd_q <= pwr_mem[rd_addr];
				on_rd_q <= on_mem[rd_addr];
			end
		end

		assign lres_rd[l] = res_rd_q;
		assign lpwr_rd[l] = pwr_rd_q;
		assign lon_rd[l] = on_rd_q;
		assign lfit[l] = (flow_q <= res_rd_q) && (LCW'(l) < nl_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (func_q == FUNC_LOAD_ROUTER) && ri_ok) begin
			rres_mem[load_addr] <= cap_q;
			rpwr_mem[load_addr] <= pwr_q;
			ron_mem[load_addr] <= 1'b0;
		end else if (cmd.commit) begin
			rres_mem[hit_r_q] <= rres_new_q;
			ron_mem[hit_r_q] <= 1'b1;
		end
		if (rd_en) begin
			rres_rd_q <= rres_mem[rd_addr];
			rpwr_rd_q <= rpwr_mem[rd_addr];
			ron_rd_q <= ron_mem[rd_addr];
		end
	end

	// request capture, winner bookkeeping and the result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= s_tuser;
			ri_q <= s_tdata[2:0];
			li_q <= s_tdata[5:3];
			cap_q <= s_tdata[37:6];
			pwr_q <= s_tdata[53:38];
			flow_q <= s_tdata[85:54];
			hit_r_q <= '0;
			hit_l_q <= '0;
		end else if (cmd.eval && status.hit) begin
			hit_r_q <= ev_idx_q;
			hit_l_q <= first_l;
			rres_new_q <= rres_rd_q - flow_q;
			lres_new_q <= lres_rd[first_l] - flow_q;
			hit_rpwr_q <= rpwr_rd_q;
			hit_lpwr_q <= lpwr_rd[first_l];
			hit_ron_q <= ron_rd_q;
			hit_lon_q <= lon_rd[first_l];
		end
		if (cmd.publish)
			out_q <= {obj_q, 3'(hit_l_q), 3'(hit_r_q), lost_q, fwd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_idx_q <= '0;
			fwd_q <= 1'b0;
			lost_q <= 1'b0;
			obj_q <= '0;
		end else begin
			if (cmd.scan_start)
				ev_idx_q <= '0;
			else if (cmd.scan_step)
				ev_idx_q <= RAW'(ev_idx_q + 1'b1);
			if (cmd.capture) begin
				fwd_q <= 1'b0;
				lost_q <= 1'b0;
			end else begin
				if (cmd.eval && status.hit)
					fwd_q <= 1'b1;
				if (cmd.mark_lost)
					lost_q <= 1'b1;
			end
			// link power first, then router power, each only on first use
			if (cmd.commit && !hit_lon_q)
				obj_q <= sat_add(obj_q, hit_lpwr_q);
			else if (cmd.add_router && !hit_ron_q)
				obj_q <= sat_add(obj_q, hit_rpwr_q);
		end
	end

	assign m_tdata = out_q;

endmodule

`default_nettype wire

// ----- sim/two_level_first_fit_packer_core_tb.sv -----
// testbench for the two-level first-fit packer core: stream requests in, placements out
// an in-bench predictor tracks residuals, in-use marks and the objective for every request
// depends on tflp_pkg and two_level_first_fit_packer_core
`timescale 1ns / 100ps

module two_level_first_fit_packer_core_tb;
	import tflp_pkg::*;

	localparam int N_ROUTERS = 8;
	localparam int N_LINKS = 8;
	localparam int STALL_LIMIT = 4000;

	localparam logic [2:0] ADDR_ROUTERS_IN_USE = 3'd0;
	localparam logic [2:0] ADDR_LINKS_IN_USE = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [2:0]        router;
		logic [2:0]        link;
		logic [31:0]       capacity;
		logic [15:0]       power;
		logic [31:0]       flow;
	} flow_request_t;

	typedef struct packed {
		logic        forwarded;
		logic        lost;
		logic [2:0]  router;
		logic [2:0]  link;
		logic [31:0] objective;
	} placement_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0] s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;

	two_level_first_fit_packer_core #(
		.MAX_ROUTERS(N_ROUTERS),
		.MAX_LINKS(N_LINKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the packer state
	logic [31:0] router_left [N_ROUTERS];
	logic [15:0] router_cost [N_ROUTERS];
	logic        router_lit [N_ROUTERS];
	logic [31:0] link_left [N_ROUTERS*N_LINKS];
	logic [15:0] link_cost [N_ROUTERS*N_LINKS];
	logic        link_lit [N_ROUTERS*N_LINKS];
	logic [31:0] power_total = '0;
	logic [3:0]  scan_routers = CFG_COUNT_RESET;
	logic [3:0]  scan_links = CFG_COUNT_RESET;

	placement_t expected_placements[$];
	int         mismatches = 0;
	bit         no_idle = 1'b0;
	int         quiet_cycles = 0;

	initial begin
		for (int i = 0; i < N_ROUTERS; i++) router_lit[i] = 1'b0;
		for (int i = 0; i < N_ROUTERS*N_LINKS; i++) link_lit[i] = 1'b0;
	end

	function automatic logic [31:0] add_power(input logic [31:0] sum, input logic [15:0] p);
		logic [32:0] s;
		s = {1'b0, sum} + {17'd0, p};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic placement_t place_flow(input flow_request_t rq);
		placement_t res;
		int nr;
		int nl;
		int k;
		bit done;
		res = '0;
		nr = (scan_routers > N_ROUTERS) ? N_ROUTERS : scan_routers;
		nl = (scan_links > N_LINKS) ? N_LINKS : scan_links;
		done = 1'b0;
		case (rq.func)
			FUNC_LOAD_ROUTER: begin
				router_left[rq.router] = rq.capacity;
				router_cost[rq.router] = rq.power;
				router_lit[rq.router] = 1'b0;
			end
			FUNC_LOAD_LINK: begin
				k = rq.router * N_LINKS + rq.link;
				link_left[k] = rq.capacity;
				link_cost[k] = rq.power;
				link_lit[k] = 1'b0;
			end
			FUNC_PACK: begin
				for (int r = 0; r < nr && !done; r++) begin
					if (rq.flow <= router_left[r]) begin
						for (int l = 0; l < nl && !done; l++) begin
							k = r * N_LINKS + l;
							if (rq.flow <= link_left[k]) begin
								if (!link_lit[k]) begin
									link_lit[k] = 1'b1;
									power_total = add_power(power_total, link_cost[k]);
								end
								link_left[k] = link_left[k] - rq.flow;
								router_left[r] = router_left[r] - rq.flow;
								if (!router_lit[r]) begin
									router_lit[r] = 1'b1;
									power_total = add_power(power_total, router_cost[r]);
								end
								res.forwarded = 1'b1;
								res.router = 3'(r);
								res.link = 3'(l);
								done = 1'b1;
							end
						end
					end
				end
				res.lost = !done;
			end
			default: ;
		endcase
		res.objective = power_total;
		return res;
	endfunction

	// sends one request; valid stays high so back-to-back requests need no extra step
	task automatic send_request(input flow_request_t rq);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.func;
		s_tdata <= {2'b00, rq.flow, rq.power, rq.capacity, rq.link, rq.router};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		expected_placements.push_back(place_flow(rq));
	endtask

	task automatic send_fields(input logic [FUNC_W-1:0] func, input logic [2:0] r,
			input logic [2:0] l, input logic [31:0] cap, input logic [15:0] pwr,
			input logic [31:0] flow);
		flow_request_t rq;
		rq = '{func: func, router: r, link: l, capacity: cap, power: pwr, flow: flow};
		send_request(rq);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_placements.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_ROUTERS_IN_USE) scan_routers = data[3:0];
		else scan_links = data[3:0];
	endtask

	task automatic set_scan_counts(input logic [31:0] routers, input logic [31:0] links);
		drain;
		apb_write(ADDR_ROUTERS_IN_USE, routers);
		apb_write(ADDR_LINKS_IN_USE, links);
	endtask

	function automatic logic [31:0] pick_capacity(input logic [31:0] span);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) return 32'd0;
		if (sel < 16) return 32'hFFFF_FFFF;
		if (sel < 30) return $urandom;
		return $urandom_range(0, span);
	endfunction

	function automatic logic [31:0] pick_flow;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) return 32'd0;
		if (sel < 14) return 32'hFFFF_FFFF;
		if (sel < 26) return $urandom;
		return $urandom_range(1, 1500);
	endfunction

	// every entry gets defined contents before any scan can read it
	task automatic test_table_load;
		for (int r = 0; r < N_ROUTERS; r++) begin
			send_fields(FUNC_LOAD_ROUTER, 3'(r), 3'd0, $urandom_range(1000, 30000),
				16'($urandom), 32'd0);
			for (int l = 0; l < N_LINKS; l++)
				send_fields(FUNC_LOAD_LINK, 3'(r), 3'(l), $urandom_range(100, 6000),
					16'($urandom), 32'd0);
		end
	endtask

	task automatic test_special_cases;
		// zero-size flow goes into a device with nothing left
		send_fields(FUNC_LOAD_ROUTER, 3'd0, 3'd0, 32'd0, 16'hFFFF, 32'd0);
		send_fields(FUNC_LOAD_LINK, 3'd0, 3'd0, 32'd0, 16'h0000, 32'd0);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd0);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
		// only the last link of the last router can take a full-range flow
		send_fields(FUNC_LOAD_ROUTER, 3'd7, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
		send_fields(FUNC_LOAD_LINK, 3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
		send_fields(FUNC_PACK, 3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'd1);
		// unused code with every bit set must leave the state alone
		send_fields(FUNC_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd40);
		// reload clears the in-use mark, so the next use charges power again
		send_fields(FUNC_LOAD_LINK, 3'd7, 3'd7, 32'd5000, 16'h1234, 32'd0);
		send_fields(FUNC_LOAD_ROUTER, 3'd7, 3'd0, 32'd5000, 16'h4321, 32'd0);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd4999);
	endtask

	task automatic test_scan_limits;
		set_scan_counts(32'd0, 32'd8);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd0);
		set_scan_counts(32'd15, 32'd0);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd0);
		set_scan_counts(32'd15, 32'd9);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd60);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
		set_scan_counts(32'd1, 32'd1);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd10);
		send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd0);
		set_scan_counts(32'd8, 32'd8);
	endtask

	task automatic test_random_traffic(input int per_phase);
		logic [31:0] cfg_r [6] = '{32'd8, 32'd1, 32'd4, 32'd15, 32'd0, 32'd8};
		logic [31:0] cfg_l [6] = '{32'd8, 32'd1, 32'd3, 32'd15, 32'd8, 32'd0};
		flow_request_t rq;
		int sel;
		int pause_at;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) begin
				set_scan_counts(cfg_r[ph], cfg_l[ph]);
			end else begin
				// random counts with the upper data bits scrambled
				set_scan_counts(($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15),
					($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15));
			end
			no_idle = (ph == 2);
			pause_at = $urandom_range(10, per_phase - 10);
			for (int i = 0; i < per_phase; i++) begin
				if (i == pause_at) drain;
				if (i == per_phase / 2 && ph == 5) no_idle = 1'b1;
				sel = $urandom_range(0, 99);
				rq.router = 3'($urandom);
				rq.link = 3'($urandom);
				rq.power = 16'($urandom);
				rq.capacity = 32'd0;
				rq.flow = $urandom;
				if (sel < 68) begin
					rq.func = FUNC_PACK;
					rq.flow = pick_flow();
				end else if (sel < 88) begin
					rq.func = FUNC_LOAD_LINK;
					rq.capacity = pick_capacity(32'd6000);
				end else if (sel < 97) begin
					rq.func = FUNC_LOAD_ROUTER;
					rq.capacity = pick_capacity(32'd30000);
				end else begin
					rq.func = FUNC_UNUSED;
					rq.capacity = $urandom;
				end
				send_request(rq);
			end
		end
		no_idle = 1'b0;
	endtask

	// each round charges a fresh router and link at full power
	task automatic test_objective_charge;
		set_scan_counts(32'd1, 32'd1);
		no_idle = 1'b1;
		for (int i = 0; i < 10; i++) begin
			send_fields(FUNC_LOAD_ROUTER, 3'd0, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
			send_fields(FUNC_LOAD_LINK, 3'd0, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
			send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, 32'd1);
		end
		no_idle = 1'b0;
		set_scan_counts(32'd8, 32'd8);
		for (int i = 0; i < 12; i++)
			send_fields(FUNC_PACK, 3'd0, 3'd0, 32'd0, 16'd0, pick_flow());
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				exp_v, act_v);
			mismatches++;
		end
	endfunction

	// result side: random stalls, compare each placement with the oldest prediction
	initial begin : result_checker
		int stall;
		placement_t exp_p;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if (expected_placements.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time,
					m_tdata);
				mismatches++;
			end else begin
				exp_p = expected_placements.pop_front();
				check_field("forwarded", 32'(exp_p.forwarded), 32'(m_tdata[0]));
				check_field("lost", 32'(exp_p.lost), 32'(m_tdata[1]));
				check_field("chosen_router", 32'(exp_p.router), 32'(m_tdata[4:2]));
				check_field("chosen_link", 32'(exp_p.link), 32'(m_tdata[7:5]));
				check_field("objective_total", exp_p.objective, m_tdata[39:8]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load;
		test_special_cases;
		test_scan_limits;
		test_random_traffic(160);
		test_objective_charge;
		drain;
		repeat (30) @(posedge clk);
		if (expected_placements.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				expected_placements.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
